// ===== rtl/core/mscc_pkg.sv =====
package mscc_pkg;

  localparam int unsigned SampleW = 8;
  localparam int unsigned TicksW  = 16;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 16;
  localparam int unsigned ModeW   = 3;

  // register indexes on the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    CFG_START_THRESHOLD  = 3'd0,
    CFG_CAP_OFF_THRESH   = 3'd1,
    CFG_MAX_START_TICKS  = 3'd2,
    CFG_MAX_ATTEMPTS     = 3'd3,
    CFG_ATTEMPT_WINDOW   = 3'd4,
    CFG_MEASURE_TICKS    = 3'd5,
    CFG_ALARM_PAUSE      = 3'd6,
    CFG_SETTLE_TICKS     = 3'd7
  } cfg_idx_t;

  // reported mode codes
  localparam logic [ModeW-1:0] MODE_CODE_MONITOR  = 3'd0;
  localparam logic [ModeW-1:0] MODE_CODE_STARTING = 3'd1;
  localparam logic [ModeW-1:0] MODE_CODE_ALARM    = 3'd2;
  localparam logic [ModeW-1:0] MODE_CODE_SETTLE   = 3'd3;
  localparam logic [ModeW-1:0] MODE_CODE_LOCKED   = 3'd4;

  // controller state, one-hot
  typedef enum logic [4:0] {
    ST_MONITOR  = 5'b00001,
    ST_STARTING = 5'b00010,
    ST_ALARM    = 5'b00100,
    ST_SETTLE   = 5'b01000,
    ST_LOCKED   = 5'b10000
  } mode_t;

  typedef struct packed {
    logic [SampleW-1:0] start_threshold;
    logic [SampleW-1:0] cap_off_threshold;
    logic [TicksW-1:0]  max_start_ticks;
    logic [ByteW-1:0]   max_attempts;
    logic [TicksW-1:0]  attempt_window_ticks;
    logic [ByteW-1:0]   measure_ticks;
    logic [TicksW-1:0]  alarm_pause_ticks;
    logic [TicksW-1:0]  settle_ticks;
  } cfg_t;

  typedef struct packed {
    logic             power_relay;
    logic             capacitor_relay;
    logic             alarm;
    logic             locked;
    logic [ModeW-1:0] mode;
  } result_t;

  localparam cfg_t CfgReset = '{
    start_threshold:      8'd223,
    cap_off_threshold:    8'd240,
    max_start_ticks:      16'd100,
    max_attempts:         8'd3,
    attempt_window_ticks: 16'd625,
    measure_ticks:        8'd2,
    alarm_pause_ticks:    16'd125,
    settle_ticks:         16'd16
  };

  function automatic result_t mode_result(input mode_t m);
    result_t r;
    r.power_relay     = (m != ST_ALARM) && (m != ST_LOCKED);
    r.capacitor_relay = (m == ST_STARTING);
    r.alarm           = (m == ST_ALARM);
    r.locked          = (m == ST_LOCKED);
    case (m)
      ST_MONITOR:  r.mode = MODE_CODE_MONITOR;
      ST_STARTING: r.mode = MODE_CODE_STARTING;
      ST_ALARM:    r.mode = MODE_CODE_ALARM;
      ST_SETTLE:   r.mode = MODE_CODE_SETTLE;
      ST_LOCKED:   r.mode = MODE_CODE_LOCKED;
      default:     r.mode = MODE_CODE_MONITOR;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/motor_capacitor_start_controller_core.sv =====
// Start controller for a single-phase motor with a switched start capacitor.
// Each input transaction carries one current sample and a 32 ms tick flag and
// yields exactly one result transaction with the relay drives, the alarm, the
// lock flag and the mode code as they stand after that sample. Samples are
// reduced to a peak over windows of measure_ticks ticks; a peak at or above
// start_threshold while monitoring begins a start, a peak below
// cap_off_threshold ends it successfully, and a start that outlasts
// max_start_ticks powers the motor off for an alarm pause. Too many starts
// inside the attempt window lock the block until reset. Throughput is one
// transaction per clock while the result channel is not stalled: a sample is
// registered on acceptance, the next state and the result are worked out
// combinationally from that register and written into the controller state
// and the output register together, from which the result is offered.
// Configuration writes are always taken (cfg_ready stays high)
// and should only be issued while no transaction is in flight.
module motor_capacitor_start_controller_core (
  input  logic                         clk,
  input  logic                         rst_n,
  // sample channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [mscc_pkg::SampleW-1:0] in_sample,
  input  logic                         in_tick,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_power_relay,
  output logic                         out_capacitor_relay,
  output logic                         out_alarm,
  output logic                         out_locked,
  output logic [mscc_pkg::ModeW-1:0]   out_mode,
  // configuration write channel
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [mscc_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [mscc_pkg::CfgDatW-1:0] cfg_data
);

  mscc_pkg::cfg_t    cfg;
  mscc_pkg::result_t step_res;

  // input stage
  logic                         s1_valid_r;
  logic [mscc_pkg::SampleW-1:0] s1_sample_r;
  logic                         s1_tick_r;

  // output stage
  logic                         out_valid_r;
  mscc_pkg::result_t            out_res_r;

  logic out_free;
  logic s1_adv;
  logic in_take;

  // output register can take a new result when empty or being drained
  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && out_free;
  // input register frees up as its transaction moves on
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  assign cfg_ready = 1'b1;

  mscc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_valid && cfg_ready),
    .wr_idx  (mscc_pkg::cfg_idx_t'(cfg_index)),
    .wr_data (cfg_data),
    .cfg     (cfg)
  );

  // controller state advances exactly once per transaction
  mscc_fsm u_fsm (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (s1_adv),
    .sample (s1_sample_r),
    .tick   (s1_tick_r),
    .cfg    (cfg),
    .result (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_sample_r <= in_sample;
      s1_tick_r   <= in_tick;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res_r <= step_res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_power_relay     = out_res_r.power_relay;
  assign out_capacitor_relay = out_res_r.capacitor_relay;
  assign out_alarm           = out_res_r.alarm;
  assign out_locked          = out_res_r.locked;
  assign out_mode            = out_res_r.mode;

endmodule

// ===== rtl/core/mscc_cfg.sv =====
module mscc_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         wr_en,
  input  mscc_pkg::cfg_idx_t           wr_idx,
  input  logic [mscc_pkg::CfgDatW-1:0] wr_data,
  output mscc_pkg::cfg_t               cfg
);

  mscc_pkg::cfg_t cfg_r;
  mscc_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_idx)
        mscc_pkg::CFG_START_THRESHOLD: cfg_nxt.start_threshold   = wr_data[7:0];
        mscc_pkg::CFG_CAP_OFF_THRESH:  cfg_nxt.cap_off_threshold = wr_data[7:0];
        mscc_pkg::CFG_MAX_START_TICKS: cfg_nxt.max_start_ticks   = wr_data;
        mscc_pkg::CFG_MAX_ATTEMPTS:    cfg_nxt.max_attempts      = wr_data[7:0];
        mscc_pkg::CFG_ATTEMPT_WINDOW:  cfg_nxt.attempt_window_ticks = wr_data;
        mscc_pkg::CFG_MEASURE_TICKS:   cfg_nxt.measure_ticks     = wr_data[7:0];
        mscc_pkg::CFG_ALARM_PAUSE:     cfg_nxt.alarm_pause_ticks = wr_data;
        mscc_pkg::CFG_SETTLE_TICKS:    cfg_nxt.settle_ticks      = wr_data;
        default:                       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= mscc_pkg::CfgReset;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/core/mscc_fsm.sv =====
module mscc_fsm (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         step,
  input  logic [mscc_pkg::SampleW-1:0] sample,
  input  logic                         tick,
  input  mscc_pkg::cfg_t               cfg,
  output mscc_pkg::result_t            result
);

  localparam logic [mscc_pkg::TicksW-1:0]  TicksMax = '1;
  localparam logic [mscc_pkg::ByteW-1:0]   ByteMax  = '1;

  mscc_pkg::mode_t                mode_r, mode_nxt;
  logic [mscc_pkg::SampleW-1:0]   peak_r, peak_nxt;
  logic [mscc_pkg::ByteW-1:0]     win_r, win_nxt;
  logic [mscc_pkg::TicksW-1:0]    phase_r, phase_nxt;
  logic [mscc_pkg::TicksW-1:0]    att_el_r, att_el_nxt;
  logic [mscc_pkg::ByteW-1:0]     att_cnt_r, att_cnt_nxt;

  logic [mscc_pkg::TicksW-1:0]    att_el_inc;
  logic [mscc_pkg::TicksW-1:0]    phase_inc;
  logic [mscc_pkg::ByteW-1:0]     att_cnt_inc;
  logic [mscc_pkg::SampleW-1:0]   peak_upd;
  logic [mscc_pkg::ByteW-1:0]     win_upd;
  logic [mscc_pkg::ByteW-1:0]     span;
  logic                           done;

  always_comb begin
    att_el_inc  = (tick && att_el_r != TicksMax) ? att_el_r + 1'b1 : att_el_r;
    phase_inc   = (tick && phase_r != TicksMax) ? phase_r + 1'b1 : phase_r;
    att_cnt_inc = (att_cnt_r != ByteMax) ? att_cnt_r + 1'b1 : att_cnt_r;
    peak_upd    = (sample > peak_r) ? sample : peak_r;
    win_upd     = (tick && win_r != ByteMax) ? win_r + 1'b1 : win_r;
    span        = (cfg.measure_ticks == '0) ? {{(mscc_pkg::ByteW-1){1'b0}}, 1'b1}
                                            : cfg.measure_ticks;
    done        = tick && (win_upd >= span);

    mode_nxt    = mode_r;
    att_el_nxt  = att_el_inc;
    att_cnt_nxt = att_cnt_r;
    phase_nxt   = phase_r;
    peak_nxt    = done ? '0 : peak_upd;
    win_nxt     = done ? '0 : win_upd;

    case (mode_r)
      mscc_pkg::ST_MONITOR: begin
        if (done && peak_upd >= cfg.start_threshold) begin
          if (att_el_inc < cfg.attempt_window_ticks) begin
            att_cnt_nxt = att_cnt_inc;
            if (att_cnt_inc > cfg.max_attempts) begin
              mode_nxt = mscc_pkg::ST_LOCKED;
            end else begin
              mode_nxt  = mscc_pkg::ST_STARTING;
              phase_nxt = '0;
            end
          end else begin
            att_el_nxt  = '0;
            att_cnt_nxt = {{(mscc_pkg::ByteW-1){1'b0}}, 1'b1};
            mode_nxt    = mscc_pkg::ST_STARTING;
            phase_nxt   = '0;
          end
        end
      end
      mscc_pkg::ST_STARTING: begin
        if (done && peak_upd < cfg.cap_off_threshold) begin
          mode_nxt  = mscc_pkg::ST_SETTLE;
          phase_nxt = '0;
        end else if (phase_inc >= cfg.max_start_ticks) begin
          mode_nxt  = mscc_pkg::ST_ALARM;
          phase_nxt = '0;
        end else begin
          phase_nxt = phase_inc;
        end
      end
      mscc_pkg::ST_ALARM: begin
        phase_nxt = phase_inc;
        if (phase_inc >= cfg.alarm_pause_ticks) begin
          mode_nxt   = mscc_pkg::ST_MONITOR;
          att_el_nxt = '0;
          peak_nxt   = '0;
          win_nxt    = '0;
        end
      end
      mscc_pkg::ST_SETTLE: begin
        phase_nxt = phase_inc;
        if (phase_inc >= cfg.settle_ticks) begin
          mode_nxt = mscc_pkg::ST_MONITOR;
          peak_nxt = '0;
          win_nxt  = '0;
        end
      end
      mscc_pkg::ST_LOCKED: begin
        // frozen until reset
        att_el_nxt = att_el_r;
        peak_nxt   = peak_r;
        win_nxt    = win_r;
      end
      default: begin
        mode_nxt = mscc_pkg::ST_MONITOR;
        peak_nxt = '0;
        win_nxt  = '0;
      end
    endcase

    // entering starting restarts the peak window
    if (mode_nxt == mscc_pkg::ST_STARTING && mode_r == mscc_pkg::ST_MONITOR) begin
      peak_nxt = '0;
      win_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= mscc_pkg::ST_MONITOR;
      peak_r    <= '0;
      win_r     <= '0;
      phase_r   <= '0;
      att_el_r  <= '0;
      att_cnt_r <= '0;
    end else if (step) begin
      mode_r    <= mode_nxt;
      peak_r    <= peak_nxt;
      win_r     <= win_nxt;
      phase_r   <= phase_nxt;
      att_el_r  <= att_el_nxt;
      att_cnt_r <= att_cnt_nxt;
    end
  end

  assign result = mscc_pkg::mode_result(mode_nxt);

endmodule

// ===== dv/motor_capacitor_start_controller_core_tb.sv =====
`timescale 1ns / 1ps

module motor_capacitor_start_controller_core_tb;

  import mscc_pkg::*;

  // receiver hold for the back-pressure test, in cycles
  localparam int unsigned HoldCycles  = 300;
  // cycles with no transaction on any channel before the run is abandoned
  localparam int unsigned QuietLimit  = 2000;
  // leave a little margin after the last result before touching registers
  localparam int unsigned DrainSlack  = 6;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;

  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [SampleW-1:0]  in_sample = '0;
  logic                in_tick = 1'b0;

  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                out_power_relay;
  logic                out_capacitor_relay;
  logic                out_alarm;
  logic                out_locked;
  logic [ModeW-1:0]    out_mode;

  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  cfg_idx_t            cfg_index = CFG_START_THRESHOLD;
  logic [CfgDatW-1:0]  cfg_data = '0;

  motor_capacitor_start_controller_core i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_sample           (in_sample),
    .in_tick             (in_tick),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_power_relay     (out_power_relay),
    .out_capacitor_relay (out_capacitor_relay),
    .out_alarm           (out_alarm),
    .out_locked          (out_locked),
    .out_mode            (out_mode),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // shadow copy of the controller: settings and state as they stand after
  // every accepted sample transaction
  // ---------------------------------------------------------------------------
  cfg_t settings = '{
    start_threshold:      8'd223,
    cap_off_threshold:    8'd240,
    max_start_ticks:      16'd100,
    max_attempts:         8'd3,
    attempt_window_ticks: 16'd625,
    measure_ticks:        8'd2,
    alarm_pause_ticks:    16'd125,
    settle_ticks:         16'd16
  };

  logic [ModeW-1:0]   ctl_mode      = MODE_CODE_MONITOR;
  logic [SampleW-1:0] peak_hold     = '0;  // running peak of the open window
  logic [ByteW-1:0]   peak_ticks    = '0;  // ticks seen in the open window
  logic [TicksW-1:0]  phase_ticks   = '0;  // ticks spent in start, pause or settle
  logic [TicksW-1:0]  attempt_ticks = '0;  // age of the attempt window, saturating
  logic [ByteW-1:0]   attempt_tally = '0;  // starts inside the attempt window

  result_t     pending_results[$];  // relay states still to come out, oldest first
  int unsigned err_count     = 0;
  int unsigned results_seen  = 0;
  int unsigned quiet_cycles  = 0;
  bit          gaps_on       = 1'b1;  // random idling on both channels
  int unsigned hold_asked    = 0;     // bumped by the test to ask for a long hold
  int unsigned hold_served   = 0;
  int unsigned stall_left    = 0;

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (!gaps_on) return 0;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(3, 1);
    if (roll < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // one sample through the controller, returns the relay states after it
  function automatic result_t step_controller(input logic [SampleW-1:0] s, input logic t);
    result_t          r;
    logic             closed;
    logic             lock_now;
    logic [SampleW-1:0] peak;
    logic [ByteW-1:0] span;
    closed   = 1'b0;
    lock_now = 1'b0;
    peak     = '0;
    if (ctl_mode != MODE_CODE_LOCKED) begin
      // zero-length window behaves as one tick
      span = (settings.measure_ticks != 0) ? settings.measure_ticks : 8'd1;

      // attempt clock runs first
      if (t && attempt_ticks != 16'hFFFF) attempt_ticks++;

      // this sample belongs to the window, even the one it closes
      if (s > peak_hold) peak_hold = s;
      if (t) begin
        if (peak_ticks != 8'hFF) peak_ticks++;
        if (peak_ticks >= span) begin
          closed     = 1'b1;
          peak       = peak_hold;
          peak_hold  = '0;
          peak_ticks = '0;
        end
      end

      case (ctl_mode)
        MODE_CODE_MONITOR: begin
          if (closed && peak >= settings.start_threshold) begin
            if (attempt_ticks < settings.attempt_window_ticks) begin
              if (attempt_tally != 8'hFF) attempt_tally++;
              lock_now = (attempt_tally > settings.max_attempts);
            end else begin
              // outside the window: a fresh window with this start as the first
              attempt_ticks = '0;
              attempt_tally = 8'd1;
            end
            if (lock_now) begin
              ctl_mode = MODE_CODE_LOCKED;
            end else begin
              ctl_mode    = MODE_CODE_STARTING;
              phase_ticks = '0;
              peak_hold   = '0;
              peak_ticks  = '0;
            end
          end
        end
        MODE_CODE_STARTING: begin
          // success takes priority over running out of time
          if (closed && peak < settings.cap_off_threshold) begin
            ctl_mode    = MODE_CODE_SETTLE;
            phase_ticks = '0;
          end else begin
            if (t && phase_ticks != 16'hFFFF) phase_ticks++;
            if (phase_ticks >= settings.max_start_ticks) begin
              ctl_mode    = MODE_CODE_ALARM;
              phase_ticks = '0;
            end
          end
        end
        MODE_CODE_ALARM: begin
          if (t && phase_ticks != 16'hFFFF) phase_ticks++;
          if (phase_ticks >= settings.alarm_pause_ticks) begin
            ctl_mode      = MODE_CODE_MONITOR;
            attempt_ticks = '0;
            peak_hold     = '0;
            peak_ticks    = '0;
          end
        end
        MODE_CODE_SETTLE: begin
          if (t && phase_ticks != 16'hFFFF) phase_ticks++;
          if (phase_ticks >= settings.settle_ticks) begin
            ctl_mode   = MODE_CODE_MONITOR;
            peak_hold  = '0;
            peak_ticks = '0;
          end
        end
        default: begin
          ctl_mode   = MODE_CODE_MONITOR;
          peak_hold  = '0;
          peak_ticks = '0;
        end
      endcase
    end

    r.power_relay     = (ctl_mode != MODE_CODE_ALARM) && (ctl_mode != MODE_CODE_LOCKED);
    r.capacitor_relay = (ctl_mode == MODE_CODE_STARTING);
    r.alarm           = (ctl_mode == MODE_CODE_ALARM);
    r.locked          = (ctl_mode == MODE_CODE_LOCKED);
    r.mode            = ctl_mode;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch on result %0d: %s is %0d, expected %0d", results_seen, what, got, want);
    err_count++;
  endtask

  // ---------------------------------------------------------------------------
  // result side: check each transaction, then decide the stall for the next
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing outstanding", 1, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_power_relay !== want.power_relay)
          report_mismatch("power_relay", int'(out_power_relay), int'(want.power_relay));
        if (out_capacitor_relay !== want.capacitor_relay)
          report_mismatch("capacitor_relay", int'(out_capacitor_relay),
                          int'(want.capacitor_relay));
        if (out_alarm !== want.alarm)
          report_mismatch("alarm", int'(out_alarm), int'(want.alarm));
        if (out_locked !== want.locked)
          report_mismatch("locked", int'(out_locked), int'(want.locked));
        if (out_mode !== want.mode)
          report_mismatch("mode", int'(out_mode), int'(want.mode));
      end
    end

    // a requested long hold overrides the random stalls
    if (hold_served != hold_asked) begin
      hold_served = hold_asked;
      stall_left  = HoldCycles;
    end
    if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (gaps_on && $urandom_range(2) == 0) begin
      stall_left = pick_gap();
      out_stall <= (stall_left != 0);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // watchdog: too long with no transaction anywhere means the block is stuck
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("timeout: no transaction for %0d cycles", quiet_cycles);
        $display("simulation failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // offer one sample, predict its result once it is taken; valid stays high
  // afterwards so back-to-back transactions need no extra assignment
  task automatic send_sample(input logic [SampleW-1:0] s, input logic t);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    in_tick   <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(step_controller(s, t));
  endtask

  // stop offering and wait until every outstanding result has been checked
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainSlack) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CfgDatW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_START_THRESHOLD: settings.start_threshold      = data[7:0];
      CFG_CAP_OFF_THRESH:  settings.cap_off_threshold    = data[7:0];
      CFG_MAX_START_TICKS: settings.max_start_ticks      = data;
      CFG_MAX_ATTEMPTS:    settings.max_attempts         = data[7:0];
      CFG_ATTEMPT_WINDOW:  settings.attempt_window_ticks = data;
      CFG_MEASURE_TICKS:   settings.measure_ticks        = data[7:0];
      CFG_ALARM_PAUSE:     settings.alarm_pause_ticks    = data;
      CFG_SETTLE_TICKS:    settings.settle_ticks         = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // write every register; the unused upper byte of the 8 bit ones gets junk
  task automatic apply_settings(input cfg_t c);
    write_reg(CFG_START_THRESHOLD, {8'($urandom_range(255)), c.start_threshold});
    write_reg(CFG_CAP_OFF_THRESH,  {8'($urandom_range(255)), c.cap_off_threshold});
    write_reg(CFG_MAX_START_TICKS, c.max_start_ticks);
    write_reg(CFG_MAX_ATTEMPTS,    {8'($urandom_range(255)), c.max_attempts});
    write_reg(CFG_ATTEMPT_WINDOW,  c.attempt_window_ticks);
    write_reg(CFG_MEASURE_TICKS,   {8'($urandom_range(255)), c.measure_ticks});
    write_reg(CFG_ALARM_PAUSE,     c.alarm_pause_ticks);
    write_reg(CFG_SETTLE_TICKS,    c.settle_ticks);
  endtask

  // current profile of a motor: quiet running, inrush above both thresholds,
  // moderate load at or below the cut-off, and plain noise, each held a few samples
  task automatic drive_motor_activity(input int unsigned n, input int unsigned tick_pct);
    int unsigned        level;
    int unsigned        hold;
    logic [SampleW-1:0] hi_floor;
    logic [SampleW-1:0] s;
    hold  = 0;
    level = 0;
    repeat (n) begin
      if (hold == 0) begin
        level = $urandom_range(9);
        hold  = $urandom_range(12, 1);
      end
      hold--;
      hi_floor = (settings.cap_off_threshold > settings.start_threshold) ?
                 settings.cap_off_threshold : settings.start_threshold;
      if (level < 4)      s = 8'($urandom_range(160, 96));
      else if (level < 7) s = 8'($urandom_range(255, hi_floor));
      else if (level < 9) s = 8'($urandom_range(settings.cap_off_threshold, 0));
      else                s = 8'($urandom_range(255));
      send_sample(s, $urandom_range(99) < tick_pct);
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset settings: one start from a strong inrush, held, then released
  task automatic test_default_start();
    send_sample(8'd0,   1'b0);
    send_sample(8'd255, 1'b0);
    send_sample(8'd128, 1'b1);
    send_sample(8'd255, 1'b1);  // window of two ticks closes at 255, start
    send_sample(8'd250, 1'b1);
    send_sample(8'd239, 1'b1);  // peak still above cut-off, keep capacitor
    send_sample(8'd100, 1'b1);
    send_sample(8'd100, 1'b1);  // peak drops, success and settle
    drain_results();
  endtask

  // every length but the attempt window zero: phases end on their first sample, success beats timeout
  task automatic test_zero_lengths();
    cfg_t c;
    c = '{start_threshold: 8'd0, cap_off_threshold: 8'd255, max_start_ticks: 16'd0,
          max_attempts: 8'd255, attempt_window_ticks: 16'd625, measure_ticks: 8'd0,
          alarm_pause_ticks: 16'd0, settle_ticks: 16'd0};
    apply_settings(c);
    send_sample(8'd128, 1'b0);
    send_sample(8'd128, 1'b1);  // one-tick window, any peak starts
    send_sample(8'd100, 1'b1);  // success and timeout together
    send_sample(8'd255, 1'b0);  // settle of zero ends at once
    send_sample(8'd255, 1'b1);
    send_sample(8'd255, 1'b1);  // no release, start time gone, alarm
    send_sample(8'd0,   1'b1);  // pause of zero, back to monitor
    send_sample(8'd0,   1'b0);
    drain_results();
  endtask

  // threshold extremes: only full scale starts, no peak counts as a release
  task automatic test_threshold_extremes();
    cfg_t c;
    c = settings;
    c.start_threshold   = 8'd255;
    c.cap_off_threshold = 8'd0;
    apply_settings(c);
    send_sample(8'd254, 1'b1);
    send_sample(8'd255, 1'b1);
    send_sample(8'd0,   1'b1);
    send_sample(8'd0,   1'b1);
    drain_results();
  endtask

  // receiver holds off while the sender keeps offering, the block must stall
  task automatic test_backpressure();
    gaps_on = 1'b0;
    hold_asked++;
    drive_motor_activity(40, 70);
    drain_results();
    gaps_on = 1'b1;
  endtask

  // every register at its top value
  task automatic test_setting_extremes();
    cfg_t c;
    c = '{start_threshold: 8'd255, cap_off_threshold: 8'd255, max_start_ticks: 16'hFFFF,
          max_attempts: 8'd255, attempt_window_ticks: 16'hFFFF, measure_ticks: 8'd255,
          alarm_pause_ticks: 16'hFFFF, settle_ticks: 16'hFFFF};
    apply_settings(c);
    drive_motor_activity(60, 90);
    drain_results();
  endtask

  // random settings per phase; a lock is kept out of reach here, either by
  // letting the attempt count saturate or by a window too short to count in
  task automatic test_random_operation();
    cfg_t c;
    for (int phase = 0; phase < 6; phase++) begin
      c.start_threshold   = ($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                                     : 8'($urandom_range(250, 140));
      c.cap_off_threshold = 8'($urandom_range(255, 120));
      c.max_start_ticks   = ($urandom_range(7) == 0) ? 16'($urandom_range(65535))
                                                     : 16'($urandom_range(40, 0));
      if ($urandom_range(1)) begin
        c.max_attempts         = 8'($urandom_range(255));
        c.attempt_window_ticks = 16'($urandom_range(1, 0));
      end else begin
        c.max_attempts         = 8'd255;
        c.attempt_window_ticks = 16'($urandom_range(200, 1));
      end
      c.measure_ticks     = 8'($urandom_range(4, 0));
      c.alarm_pause_ticks = 16'($urandom_range(30, 0));
      c.settle_ticks      = 16'($urandom_range(20, 0));
      apply_settings(c);
      gaps_on = (phase != 2);  // one phase runs flat out
      drive_motor_activity(100, $urandom_range(100, 30));
      drain_results();
    end
    gaps_on = 1'b1;
  endtask

  // every tick closes a window and moves the mode on, so starts come every
  // third sample and the attempt count runs into its ceiling
  task automatic test_attempt_saturation();
    cfg_t c;
    c = '{start_threshold: 8'd0, cap_off_threshold: 8'd255, max_start_ticks: 16'hFFFF,
          max_attempts: 8'd255, attempt_window_ticks: 16'hFFFF, measure_ticks: 8'd1,
          alarm_pause_ticks: 16'd0, settle_ticks: 16'd0};
    apply_settings(c);
    repeat (820) send_sample(8'($urandom_range(254)), 1'b1);
    drain_results();
  endtask

  // too many starts in one window lock the block for good, inputs then ignored
  task automatic test_attempt_lock();
    cfg_t        c;
    int unsigned tries;
    c = '{start_threshold: 8'd200, cap_off_threshold: 8'd150, max_start_ticks: 16'hFFFF,
          max_attempts: 8'd2, attempt_window_ticks: 16'hFFFF, measure_ticks: 8'd1,
          alarm_pause_ticks: 16'd0, settle_ticks: 16'd0};
    apply_settings(c);
    tries = 0;
    while (ctl_mode != MODE_CODE_LOCKED && tries < 40) begin
      send_sample(8'd255, 1'b1);  // start
      send_sample(8'd0,   1'b1);  // released, settle
      send_sample(8'd0,   1'b1);  // settle over, monitor
      tries++;
    end
    drive_motor_activity(30, 80);
    drain_results();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_start();
    test_zero_lengths();
    test_threshold_extremes();
    test_backpressure();
    test_setting_extremes();
    test_random_operation();
    test_attempt_saturation();
    test_attempt_lock();

    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
